### design/rem_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the resource element mapper.
// No dependencies; every other design file imports this package.
package rem_pkg;

  localparam int unsigned IO_LANES        = 4;
  localparam int unsigned MAX_LANES       = 4;
  localparam int unsigned TONES_PER_BLOCK = 12;

  localparam int unsigned SYM_W   = 4;
  localparam int unsigned BLK_W   = 9;
  localparam int unsigned TONE_W  = $clog2(TONES_PER_BLOCK);
  localparam int unsigned SC_W    = 12;
  localparam int unsigned SCX_W   = BLK_W + TONE_W;
  localparam int unsigned ANT_W   = 3;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 12;

  // Lane limit of this build: the smaller of the port lanes and MAX_LANES.
  localparam int unsigned LANE_LIMIT = (MAX_LANES < IO_LANES) ? MAX_LANES : IO_LANES;

  typedef enum logic [CIDX_W-1:0] {
    REG_BLOCK_START      = 3'd0,
    REG_BLOCK_COUNT      = 3'd1,
    REG_SYMBOL_START     = 3'd2,
    REG_SYMBOL_COUNT     = 3'd3,
    REG_GRID_SYMBOLS     = 3'd4,
    REG_GRID_SUBCARRIERS = 3'd5,
    REG_ANTENNA_COUNT    = 3'd6,
    REG_COLUMN_COUNT     = 3'd7
  } rem_reg_e;

  typedef struct packed {
    logic [BLK_W-1:0] block_start;
    logic [BLK_W-1:0] block_count;
    logic [SYM_W-1:0] symbol_start;
    logic [SYM_W-1:0] symbol_count;
    logic [SYM_W-1:0] grid_symbols;
    logic [SC_W-1:0]  grid_subcarriers;
    logic [ANT_W-1:0] antenna_count;
    logic [ANT_W-1:0] column_count;
  } rem_cfg_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] value;
  } rem_cfg_wr_t;

  typedef struct packed {
    logic                     last_row;
    logic signed [SAMP_W-1:0] lane0_re;
    logic signed [SAMP_W-1:0] lane0_im;
    logic signed [SAMP_W-1:0] lane1_re;
    logic signed [SAMP_W-1:0] lane1_im;
    logic signed [SAMP_W-1:0] lane2_re;
    logic signed [SAMP_W-1:0] lane2_im;
    logic signed [SAMP_W-1:0] lane3_re;
    logic signed [SAMP_W-1:0] lane3_im;
  } rem_row_t;

  typedef struct packed {
    logic [SYM_W-1:0]         symbol_index;
    logic [SC_W-1:0]          subcarrier_index;
    logic [IO_LANES-1:0]      lane_enable;
    logic signed [SAMP_W-1:0] out0_re;
    logic signed [SAMP_W-1:0] out0_im;
    logic signed [SAMP_W-1:0] out1_re;
    logic signed [SAMP_W-1:0] out1_im;
    logic signed [SAMP_W-1:0] out2_re;
    logic signed [SAMP_W-1:0] out2_im;
    logic signed [SAMP_W-1:0] out3_re;
    logic signed [SAMP_W-1:0] out3_im;
    logic                     final_write;
  } rem_wr_t;

  // Position handed from the walker to the write stage.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic [SC_W-1:0]  subcarrier;
    logic             final_write;
  } rem_pos_t;

  // Subcarrier of a block and tone: block * TONES_PER_BLOCK + tone.
  function automatic logic [SCX_W-1:0] rem_subcarrier(input logic [BLK_W-1:0] blk,
                                                       input logic [TONE_W-1:0] tone);
    return SCX_W'(blk) * SCX_W'(TONES_PER_BLOCK) + SCX_W'(tone);
  endfunction

endpackage

### design/rem_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the resource element mapper.
// Depends on rem_pkg for the payload types.
interface rem_row_if import rem_pkg::*; ();
  logic     valid;
  logic     ready;
  rem_row_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rem_wr_if import rem_pkg::*; ();
  logic    valid;
  logic    ready;
  rem_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rem_cfg_if import rem_pkg::*; ();
  logic        valid;
  logic        ready;
  rem_cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/rem_walker.sv
`timescale 1ns / 1ps
// Allocation walker: tracks symbol, block and tone and skips past the grid edge.
// Depends on rem_pkg.
module rem_walker import rem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_cfg_t cfg_i,
  input  logic     reload_i,
  input  logic     step_i,
  input  logic     last_i,
  output rem_pos_t pos_o
);

  // The stored position is always settled. start_q means the walk sits at
  // the allocation start, which is worked out from the live registers.
  logic              start_q;
  logic              exh_q;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [TONE_W-1:0] tone_q, tone_d;
  logic              exh_d;

  logic              row_empty, start_ok;
  logic [SYM_W-1:0]  eff_sym, sym_inc;
  logic [BLK_W-1:0]  eff_blk, blk_n;
  logic [TONE_W-1:0] eff_tone, tone_n;
  logic              eff_exh, pos_ok;
  logic [SCX_W-1:0]  eff_sc;

  function automatic logic sym_out(input logic [SYM_W-1:0] s, input rem_cfg_t c);
    logic [SYM_W:0] sym_end;
    sym_end = (SYM_W+1)'(c.symbol_start) + (SYM_W+1)'(c.symbol_count);
    return ((SYM_W+1)'(s) >= sym_end) || (s >= c.grid_symbols);
  endfunction

  always_comb begin
    row_empty = (cfg_i.block_count == '0) ||
                (rem_subcarrier(cfg_i.block_start, '0) >= SCX_W'(cfg_i.grid_subcarriers));
    start_ok  = !row_empty && !sym_out(cfg_i.symbol_start, cfg_i);
    if (start_q) begin
      eff_sym  = cfg_i.symbol_start;
      eff_blk  = cfg_i.block_start;
      eff_tone = '0;
      eff_exh  = !start_ok;
    end else begin
      eff_sym  = sym_q;
      eff_blk  = blk_q;
      eff_tone = tone_q;
      eff_exh  = exh_q;
    end
    eff_sc = rem_subcarrier(eff_blk, eff_tone);
  end

  // Advance by one tone, then settle. The current row is known to be non-empty,
  // so running off its end moves to the next symbol or ends the allocation.
  always_comb begin
    if (eff_tone == TONE_W'(TONES_PER_BLOCK - 1)) begin
      tone_n = '0;
      blk_n  = eff_blk + BLK_W'(1);
    end else begin
      tone_n = eff_tone + TONE_W'(1);
      blk_n  = eff_blk;
    end
    pos_ok  = ((BLK_W+1)'(blk_n) <
               (BLK_W+1)'(cfg_i.block_start) + (BLK_W+1)'(cfg_i.block_count)) &&
              (rem_subcarrier(blk_n, tone_n) < SCX_W'(cfg_i.grid_subcarriers));
    sym_inc = eff_sym + SYM_W'(1);
    sym_d   = eff_sym;
    blk_d   = blk_n;
    tone_d  = tone_n;
    exh_d   = 1'b0;
    if (!pos_ok) begin
      sym_d  = sym_inc;
      blk_d  = cfg_i.block_start;
      tone_d = '0;
      exh_d  = sym_out(sym_inc, cfg_i);
    end
  end

  always_comb begin
    pos_o.valid       = !eff_exh;
    pos_o.symbol      = eff_sym;
    pos_o.subcarrier  = eff_sc[SC_W-1:0];
    pos_o.final_write = last_i || exh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      exh_q   <= 1'b0;
    end else if (reload_i) begin
      start_q <= 1'b1;
    end else if (step_i) begin
      if (last_i) begin
        start_q <= 1'b1;
      end else if (!eff_exh) begin
        start_q <= 1'b0;
        exh_q   <= exh_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !reload_i && !last_i && !eff_exh) begin
      sym_q  <= sym_d;
      blk_q  <= blk_d;
      tone_q <= tone_d;
    end
  end

  a_settled_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_q && !exh_q |-> (eff_sc < SCX_W'(cfg_i.grid_subcarriers)) &&
                           (sym_q < cfg_i.grid_symbols))
    else $error("settled position lies outside the grid");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> start_q)
    else $error("last row did not return the walk to the allocation start");

  a_start_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q && !start_ok |-> !pos_o.valid)
    else $error("empty allocation produced a write");

endmodule

### design/resource_element_mapper.sv
`timescale 1ns / 1ps
// Top level of the resource element mapper: configuration registers, walker
// and registered grid-write output. Depends on rem_pkg, rem_intf and rem_walker.
//
//   Port     Dir   Payload        Purpose
//   row_i    in    rem_row_t      precoded row, up to four antenna samples
//   wr_o     out   rem_wr_t       grid write: position, samples, lane enables
//   cfg_i    in    rem_cfg_wr_t   register write: index and value
//
// Each accepted row is mapped combinationally; the write appears on wr_o in the
// cycle after the transfer, and a new row is taken every cycle while wr_o is not stalled.
// The only feedback loop is the position update in rem_walker.
// Reset sets the configuration registers to their defaults, clears the output valid and puts the walk at the start.
// A stall on wr_o holds the output register and drops row_i.ready only while
// a write is pending; the configuration port never stalls.
module resource_element_mapper import rem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rem_row_if.sink   row_i,
  rem_wr_if.source  wr_o,
  rem_cfg_if.sink   cfg_i
);

  rem_cfg_t            cfg_q;
  rem_pos_t            pos;
  rem_wr_t             wr_q, wr_d;
  logic                wr_valid_q;
  logic                row_xfer, cfg_xfer;
  logic [ANT_W-1:0]    lanes;
  logic [IO_LANES-1:0] lane_mask;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;

  // The output register frees up when its write is taken, so a row can be
  // accepted in the same cycle that the previous write leaves.
  assign row_i.ready = !wr_valid_q || wr_o.ready;
  assign row_xfer    = row_i.valid && row_i.ready;

  // Register writes are truncated to each register's width. Any write,
  // including one to an unused index, sends the walk back to the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_start      <= '0;
      cfg_q.block_count      <= BLK_W'(1);
      cfg_q.symbol_start     <= '0;
      cfg_q.symbol_count     <= SYM_W'(14);
      cfg_q.grid_symbols     <= SYM_W'(14);
      cfg_q.grid_subcarriers <= SC_W'(3300);
      cfg_q.antenna_count    <= ANT_W'(4);
      cfg_q.column_count     <= ANT_W'(4);
    end else if (cfg_xfer) begin
      case (cfg_i.data.index)
        REG_BLOCK_START:      cfg_q.block_start      <= cfg_i.data.value[BLK_W-1:0];
        REG_BLOCK_COUNT:      cfg_q.block_count      <= cfg_i.data.value[BLK_W-1:0];
        REG_SYMBOL_START:     cfg_q.symbol_start     <= cfg_i.data.value[SYM_W-1:0];
        REG_SYMBOL_COUNT:     cfg_q.symbol_count     <= cfg_i.data.value[SYM_W-1:0];
        REG_GRID_SYMBOLS:     cfg_q.grid_symbols     <= cfg_i.data.value[SYM_W-1:0];
        REG_GRID_SUBCARRIERS: cfg_q.grid_subcarriers <= cfg_i.data.value[SC_W-1:0];
        REG_ANTENNA_COUNT:    cfg_q.antenna_count    <= cfg_i.data.value[ANT_W-1:0];
        REG_COLUMN_COUNT:     cfg_q.column_count     <= cfg_i.data.value[ANT_W-1:0];
        default: ;
      endcase
    end
  end

  rem_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .reload_i (cfg_xfer),
    .step_i   (row_xfer),
    .last_i   (row_i.data.last_row),
    .pos_o    (pos)
  );

  // Active lanes: the smaller of the antenna and column counts, clipped to the
  // lanes this build carries. A zero count writes with every lane disabled.
  always_comb begin
    lanes = (cfg_q.antenna_count < cfg_q.column_count) ? cfg_q.antenna_count
                                                        : cfg_q.column_count;
    if (lanes > ANT_W'(LANE_LIMIT)) begin
      lanes = ANT_W'(LANE_LIMIT);
    end
    for (int k = 0; k < IO_LANES; k++) begin
      lane_mask[k] = (ANT_W'(k) < lanes);
    end
  end

  // Disabled lanes carry zero samples.
  always_comb begin
    wr_d.symbol_index     = pos.symbol;
    wr_d.subcarrier_index = pos.subcarrier;
    wr_d.lane_enable      = lane_mask;
    wr_d.out0_re          = lane_mask[0] ? row_i.data.lane0_re : '0;
    wr_d.out0_im          = lane_mask[0] ? row_i.data.lane0_im : '0;
    wr_d.out1_re          = lane_mask[1] ? row_i.data.lane1_re : '0;
    wr_d.out1_im          = lane_mask[1] ? row_i.data.lane1_im : '0;
    wr_d.out2_re          = lane_mask[2] ? row_i.data.lane2_re : '0;
    wr_d.out2_im          = lane_mask[2] ? row_i.data.lane2_im : '0;
    wr_d.out3_re          = lane_mask[3] ? row_i.data.lane3_re : '0;
    wr_d.out3_im          = lane_mask[3] ? row_i.data.lane3_im : '0;
    wr_d.final_write      = pos.final_write;
  end

  // Output register. A row that falls outside the allocation produces no write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else if (row_i.ready) begin
      wr_valid_q <= row_xfer && pos.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_xfer && pos.valid) begin
      wr_q <= wr_d;
    end
  end

  assign wr_o.valid = wr_valid_q;
  assign wr_o.data  = wr_q;

  a_write_follows_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_xfer && pos.valid |=> wr_valid_q)
    else $error("mapped row did not produce a write");

  a_no_write_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_xfer && !pos.valid && (!wr_valid_q || wr_o.ready) |=> !wr_valid_q)
    else $error("write produced after the allocation ended");

  a_lane_enable_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_q |-> ((wr_q.lane_enable[0] || (wr_q.out0_re == '0 && wr_q.out0_im == '0)) &&
                    (wr_q.lane_enable[3] || (wr_q.out3_re == '0 && wr_q.out3_im == '0))))
    else $error("disabled lane carries a sample");

endmodule
